// ----- rtl/arpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

  // Cache geometry
  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 2'd1;

  // Operation modes
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_PACKET = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_STORED  = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_LEARNED = 3'd4;
  localparam logic [2:0] ST_REPLY   = 3'd5;

  // Header values a packet must carry, and the ARP request opcode
  localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] ARP_PROTO_IPV4 = 16'h0800;
  localparam logic [7:0]  ARP_HW_LEN     = 8'd6;
  localparam logic [7:0]  ARP_PROTO_LEN  = 8'd4;
  localparam logic [15:0] OPCODE_REQUEST = 16'h0001;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] entry_ip;
    logic [47:0] entry_mac;
    logic        frame_short;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_opcode;
    logic [31:0] target_ip;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] result_mac;
    logic [31:0] result_ip;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_full;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/arpc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module arpc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output arpc_pkg::dp_cmd_t     cmd,
  input  wire arpc_pkg::dp_sts_t sts
);
  import arpc_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait until the output register can take the result
        if (!sts.out_full) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/arpc_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module arpc_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire arpc_pkg::in_item_t              in_item,
  output arpc_pkg::out_item_t                  out_item,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  input  wire logic                            cfg_we,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire arpc_pkg::dp_cmd_t               cmd,
  output arpc_pkg::dp_sts_t                    sts
);
  import arpc_pkg::*;

  // Cache storage: valid bits reset, payload written before it is read
  logic [CACHE_ENTRIES-1:0] entry_valid;
  logic [31:0]              entry_ip_store  [CACHE_ENTRIES];
  logic [47:0]              entry_mac_store [CACHE_ENTRIES];

  logic [31:0] own_ip;
  in_item_t    item;

  logic [CACHE_ENTRIES-1:0] hit_vec;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic                     any_free;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         wr_idx;
  logic                     pkt_ok;
  logic                     do_add;
  out_item_t                result;

  // Local IP register; the local MAC only matters to the transmit side,
  // so a write to it is accepted and has no effect here
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
    end else if (cfg_we && cfg_index == REG_OWN_IP) begin
      own_ip <= cfg_data[31:0];
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
  end

  // Parallel compare against every entry
  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      hit_vec[i] = entry_valid[i] && (entry_ip_store[i] == item.entry_ip);
    end
  end

  // Lowest matching entry and lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Operation decode and result
  always_comb begin
    pkt_ok = !item.frame_short && item.hw_type == HTYPE_ETHERNET &&
             item.proto_type == ARP_PROTO_IPV4 && item.hw_len == ARP_HW_LEN &&
             item.proto_len == ARP_PROTO_LEN;
    do_add = 1'b0;
    result = '0;
    result.status = ST_DROPPED;
    unique case (item.mode)
      MODE_LOOKUP: begin
        if (hit) begin
          result.status     = ST_HIT;
          result.result_mac = entry_mac_store[hit_idx];
        end else begin
          result.status = ST_MISS;
        end
      end
      MODE_ADD: begin
        do_add        = 1'b1;
        result.status = ST_STORED;
      end
      MODE_PACKET: begin
        if (pkt_ok) begin
          do_add = 1'b1;
          if (item.arp_opcode == OPCODE_REQUEST && item.target_ip == own_ip) begin
            result.status     = ST_REPLY;
            result.result_mac = item.entry_mac;
            result.result_ip  = item.entry_ip;
          end else begin
            result.status = ST_LEARNED;
          end
        end
      end
      default: result.status = ST_DROPPED;
    endcase
    // matching entry, else lowest free slot, else entry 0
    if (hit) begin
      wr_idx = hit_idx;
    end else if (any_free) begin
      wr_idx = free_idx;
    end else begin
      wr_idx = '0;
    end
  end

  // Cache write-back
  always_ff @(posedge clk) begin
    if (cmd.exec && do_add) begin
      entry_ip_store[wr_idx]  <= item.entry_ip;
      entry_mac_store[wr_idx] <= item.entry_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.exec && do_add) begin
      entry_valid[wr_idx] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_item <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_full = out_valid && out_stall;

endmodule

`default_nettype wire

// ----- rtl/arp_cache_and_responder_unit.sv -----
// Each input item is first captured into the item register, then compared,
// written back and its result placed in the output register; no new item
// is taken before that, and a result held by out_stall delays the write-back.
// The next item is accepted while a finished result still waits.
// Reset (rst, synchronous, active high) clears all valid marks, own_ip and
// the handshake state at once; entry IP and MAC storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_and_responder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire arpc_pkg::in_item_t              in_item,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output arpc_pkg::out_item_t                  out_item,
  input  wire logic                            cfg_we,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import arpc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  arpc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // one item in flight: the cycle after a transaction the input is held off
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in flight");

  // the requester IP is reported only with a reply
  a_ip_only_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != ST_REPLY) |-> (out_item.result_ip == '0))
    else $error("result_ip nonzero without reply");

  // a MAC is reported only on a hit or a reply
  a_mac_only_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != ST_HIT && out_item.status != ST_REPLY)
      |-> (out_item.result_mac == '0))
    else $error("result_mac nonzero without hit or reply");

  // a command to execute never overwrites a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.exec)
    else $error("held result overwritten");
`endif

endmodule

`default_nettype wire
